// ===== src/dual_pid_differential_drive_macros.svh =====
// ----------------------------------------------------------------------------
// Dual PID differential drive - assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DUAL_PID_DIFFERENTIAL_DRIVE_MACROS_SVH
`define DUAL_PID_DIFFERENTIAL_DRIVE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is applied.
`define DPDD_ASSERT_HOLDS(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is applied.
`define DPDD_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual PID differential drive - package
// Field widths, register codes, reset values, sequencer states and the
// request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package dpdd_pkg;

	localparam int INTEGRAL_WIDTH_DEF = 32;

	localparam int DIST_W     = 9;
	localparam int LIGHT_W    = 10;
	localparam int DT_W       = 16;
	localparam int POWER_W    = 8;
	localparam int LANE_W     = 2;
	localparam int GAIN_W     = 8;
	localparam int ERR_W      = 11;
	localparam int DIFF_W     = 12;
	localparam int MUL_A_W    = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam int BASE_POWER = 127;

	localparam logic [LANE_W-1:0]  LANE_ONE   = 2'd1;
	localparam logic [LANE_W-1:0]  LANE_TWO   = 2'd2;
	localparam logic [LANE_W-1:0]  LANE_THREE = 2'd3;

	localparam logic [LANE_W-1:0]  RST_LANE        = LANE_ONE;
	localparam logic [DIST_W-1:0]  RST_REAR_TARGET = 9'd30;
	localparam logic [POWER_W-1:0] RST_POWER_MAX   = 8'd255;
	localparam logic [POWER_W-1:0] RST_POWER_MIN   = 8'd0;
	localparam logic [LIGHT_W-1:0] RST_LINE_THRESH = 10'd512;
	localparam logic [GAIN_W-1:0]  RST_GAIN        = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LANE        = 3'd0,
		REG_REAR_TARGET = 3'd1,
		REG_POWER_MAX   = 3'd2,
		REG_POWER_MIN   = 3'd3,
		REG_LINE_THRESH = 3'd4,
		REG_ALIGN_KP    = 3'd5,
		REG_ALIGN_KI    = 3'd6,
		REG_ALIGN_KD    = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RI,
		ST_AI,
		ST_AACC,
		ST_RDIV,
		ST_ADIV,
		ST_KP,
		ST_KI,
		ST_KD,
		ST_SUM,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] dividend;
		logic [DT_W-1:0]          divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DIFF_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/dpdd_ifs.sv =====
// ----------------------------------------------------------------------------
// Dual PID differential drive - channel interfaces
// Valid/ready channels for sensor samples in and drive commands out.
// ----------------------------------------------------------------------------
interface dpdd_in_if import dpdd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIST_W-1:0]  rear_distance;
	logic [DIST_W-1:0]  side_front_distance;
	logic [DIST_W-1:0]  side_rear_distance;
	logic [LIGHT_W-1:0] light_left;
	logic [LIGHT_W-1:0] light_right;
	logic [DT_W-1:0]    elapsed_ms;

	modport source (
		output valid, rear_distance, side_front_distance, side_rear_distance,
			light_left, light_right, elapsed_ms,
		input  ready
	);
	modport sink (
		input  valid, rear_distance, side_front_distance, side_rear_distance,
			light_left, light_right, elapsed_ms,
		output ready
	);
endinterface

interface dpdd_out_if import dpdd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POWER_W-1:0] power_right;
	logic [POWER_W-1:0] power_left;
	logic               thruster_right_on;
	logic               thruster_left_on;

	modport source (
		output valid, power_right, power_left, thruster_right_on, thruster_left_on,
		input  ready
	);
	modport sink (
		input  valid, power_right, power_left, thruster_right_on, thruster_left_on,
		output ready
	);
endinterface

// ===== src/dpdd_mul.sv =====
// ----------------------------------------------------------------------------
// Dual PID differential drive - shared multiplier
// Signed narrow-by-wide product with a register on its output.
// ----------------------------------------------------------------------------
module dpdd_mul import dpdd_pkg::*; #(
	parameter int IW = INTEGRAL_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic signed [MUL_A_W-1:0]     a,
	input  logic signed [IW-1:0]          b,
	output logic signed [MUL_A_W+IW-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== src/dpdd_div.sv =====
// ----------------------------------------------------------------------------
// Dual PID differential drive - iterative divider
// Restoring signed-by-unsigned division, one quotient bit per cycle,
// truncated toward zero; a zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module dpdd_div import dpdd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIFF_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DT_W-1:0]   dvs_q;
	logic [DT_W-1:0]   rem_q;
	logic [DIFF_W-1:0] quo_q;
	logic              neg_q;

	logic [DT_W:0]     trial;
	logic              fits;
	logic [DT_W-1:0]   rem_nxt;
	logic [DIFF_W-1:0] mag;
	logic              dvs_zero;

	assign dvs_zero = (req.divisor == '0);
	assign mag      = req.dividend[DIFF_W-1] ? DIFF_W'(-req.dividend) : req.dividend;
	assign trial    = {rem_q, quo_q[DIFF_W-1]};
	assign fits     = (trial >= {1'b0, dvs_q});
	assign rem_nxt  = fits ? DT_W'(trial - {1'b0, dvs_q}) : trial[DT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !dvs_zero;
				done_q <= dvs_zero;
				cnt_q  <= CNT_W'(DIFF_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= dvs_zero ? '0 : mag;
			neg_q <= req.dividend[DIFF_W-1] && !dvs_zero;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIFF_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? $signed(DIFF_W'(-quo_q)) : $signed(quo_q);

endmodule

// ===== src/dual_pid_differential_drive.sv =====
// ----------------------------------------------------------------------------
// Dual PID differential drive - top level
// Distance and alignment PID loops mixed into left/right drive power.
// ----------------------------------------------------------------------------
// Each input beat is one sensor sample; each produces exactly one output beat
// with the clamped right and left motor power and the two side-thruster flags.
// The block works on one sample at a time: in_ch.ready is high only while the
// sequencer is idle. Each sample runs two 12-step derivative divisions on the
// shared divider, skipped when elapsed_ms is zero, and one multiply per cycle on
// the shared multiplier for the two integral updates and the three alignment
// gain products. The finished result sits in an output register, so a new
// sample is accepted while it waits; if the downstream side still holds the
// previous beat when the next one is ready, the sequencer holds.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only be changed while no sample is in flight.
// ----------------------------------------------------------------------------
module dual_pid_differential_drive import dpdd_pkg::*; #(
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dpdd_in_if.sink               in_ch,
	dpdd_out_if.source            out_ch
);

`include "dual_pid_differential_drive_macros.svh"

	localparam int IW = INTEGRAL_WIDTH;
	localparam int PW = MUL_A_W + IW;   // product width
	localparam int AW = PW + 1;         // accumulate / saturate width

	localparam logic signed [AW-1:0] IMAX = {{(AW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic signed [AW-1:0] IMIN = ~IMAX;

	// configuration registers
	logic [LANE_W-1:0]        lane_q;
	logic [DIST_W-1:0]        rear_target_q;
	logic [POWER_W-1:0]       power_max_q;
	logic [POWER_W-1:0]       power_min_q;
	logic [LIGHT_W-1:0]       line_thresh_q;
	logic signed [GAIN_W-1:0] kp_q;
	logic signed [GAIN_W-1:0] ki_q;
	logic signed [GAIN_W-1:0] kd_q;

	// loop state
	logic signed [ERR_W-1:0]  rear_prev_q;
	logic signed [ERR_W-1:0]  align_prev_q;
	logic signed [IW-1:0]     rear_int_q;
	logic signed [IW-1:0]     align_int_q;
	logic                     primed_q;

	// per-sample working registers
	state_t                   state_q, state_d;
	logic [DT_W-1:0]          dt_q;
	logic [LIGHT_W-1:0]       light_l_q;
	logic [LIGHT_W-1:0]       light_r_q;
	logic signed [ERR_W-1:0]  e_rear_q;
	logic signed [ERR_W-1:0]  e_align_q;
	logic signed [DIFF_W-1:0] rdiff_q;
	logic signed [DIFF_W-1:0] adiff_q;
	logic signed [DIFF_W-1:0] d_rear_q;
	logic signed [DIFF_W-1:0] d_align_q;
	logic signed [AW-1:0]     rt_q;
	logic signed [AW-1:0]     al_q;
	logic signed [AW-1:0]     right_q;
	logic signed [AW-1:0]     left_q;

	// output register
	logic                     out_valid_q;
	logic [POWER_W-1:0]       power_right_q;
	logic [POWER_W-1:0]       power_left_q;
	logic                     thr_r_q;
	logic                     thr_l_q;

	// datapath nets
	logic                     in_fire;
	logic                     out_load;
	logic signed [ERR_W-1:0]  e_rear_in;
	logic signed [ERR_W-1:0]  e_align_in;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [IW-1:0]     mul_b;
	logic signed [PW-1:0]     prod_q;
	logic signed [AW-1:0]     prod_x;
	logic signed [AW-1:0]     int_sum;
	logic signed [IW-1:0]     int_sat;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	logic [POWER_W-1:0]       pr_clamp;
	logic [POWER_W-1:0]       pl_clamp;
	logic                     thr_r_d;
	logic                     thr_l_d;

	function automatic logic [POWER_W-1:0] clamp_power(
		input logic signed [AW-1:0] v,
		input logic [POWER_W-1:0]   pmax,
		input logic [POWER_W-1:0]   pmin
	);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		logic signed [AW-1:0] r;
		hi = $signed({{(AW-POWER_W){1'b0}}, pmax});
		lo = $signed({{(AW-POWER_W){1'b0}}, pmin});
		r  = (v > hi) ? hi : v;
		r  = (r < lo) ? lo : r;
		return r[POWER_W-1:0];
	endfunction

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	assign e_rear_in  = $signed({2'b00, rear_target_q}) - $signed({2'b00, in_ch.rear_distance});
	assign e_align_in = $signed({2'b00, in_ch.side_front_distance})
		- $signed({2'b00, in_ch.side_rear_distance});

	// -------------------------------------------------------------------------
	// Configuration writes
	// -------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q        <= RST_LANE;
			rear_target_q <= RST_REAR_TARGET;
			power_max_q   <= RST_POWER_MAX;
			power_min_q   <= RST_POWER_MIN;
			line_thresh_q <= RST_LINE_THRESH;
			kp_q          <= RST_GAIN;
			ki_q          <= RST_GAIN;
			kd_q          <= RST_GAIN;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LANE:        lane_q        <= cfg_data[LANE_W-1:0];
				REG_REAR_TARGET: rear_target_q <= cfg_data[DIST_W-1:0];
				REG_POWER_MAX:   power_max_q   <= cfg_data[POWER_W-1:0];
				REG_POWER_MIN:   power_min_q   <= cfg_data[POWER_W-1:0];
				REG_LINE_THRESH: line_thresh_q <= cfg_data[LIGHT_W-1:0];
				REG_ALIGN_KP:    kp_q          <= cfg_data[GAIN_W-1:0];
				REG_ALIGN_KI:    ki_q          <= cfg_data[GAIN_W-1:0];
				REG_ALIGN_KD:    kd_q          <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------------------------
	// Shared multiplier: operands picked by the step being issued
	// -------------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RI: begin
				mul_a = e_rear_q;
				mul_b = $signed({{(IW-DT_W){1'b0}}, dt_q});
			end
			ST_AI: begin
				mul_a = e_align_q;
				mul_b = $signed({{(IW-DT_W){1'b0}}, dt_q});
			end
			ST_KP: begin
				mul_a = MUL_A_W'(kp_q);
				mul_b = IW'(e_align_q);
			end
			ST_KI: begin
				mul_a = MUL_A_W'(ki_q);
				mul_b = align_int_q;
			end
			ST_KD: begin
				mul_a = MUL_A_W'(kd_q);
				mul_b = IW'(d_align_q);
			end
			default: ;
		endcase
	end

	dpdd_mul #(.IW(IW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign prod_x = AW'(prod_q);

	// integral update: add the product of the previous step, then saturate
	always_comb begin
		int_sum = prod_x + ((state_q == ST_AI) ? AW'(rear_int_q) : AW'(align_int_q));
		if (int_sum > IMAX) begin
			int_sat = IMAX[IW-1:0];
		end else if (int_sum < IMIN) begin
			int_sat = IMIN[IW-1:0];
		end else begin
			int_sat = int_sum[IW-1:0];
		end
	end

	// -------------------------------------------------------------------------
	// Shared divider for the two derivatives
	// -------------------------------------------------------------------------
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = rdiff_q;
		div_req.divisor  = dt_q;
		if (state_q == ST_AACC) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_RDIV && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = adiff_q;
		end
	end

	dpdd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// -------------------------------------------------------------------------
	// Sequencer
	// -------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = ST_RI;
			end
			ST_RI:   state_d = ST_AI;
			ST_AI:   state_d = ST_AACC;
			ST_AACC: state_d = ST_RDIV;
			ST_RDIV: if (div_rsp.done) state_d = ST_ADIV;
			ST_ADIV: if (div_rsp.done) state_d = ST_KP;
			ST_KP:   state_d = ST_KI;
			ST_KI:   state_d = ST_KD;
			ST_KD:   state_d = ST_SUM;
			ST_SUM:  state_d = ST_MIX;
			ST_MIX:  state_d = ST_OUT;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// loop state that survives between samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_prev_q  <= '0;
			align_prev_q <= '0;
			rear_int_q   <= '0;
			align_int_q  <= '0;
			primed_q     <= 1'b0;
		end else begin
			if (in_fire) begin
				rear_prev_q  <= e_rear_in;
				align_prev_q <= e_align_in;
				primed_q     <= 1'b1;
			end
			if (state_q == ST_AI) rear_int_q <= int_sat;
			if (state_q == ST_AACC) align_int_q <= int_sat;
		end
	end

	// per-sample payload; the first sample sees its own error as the previous one
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dt_q      <= in_ch.elapsed_ms;
			light_l_q <= in_ch.light_left;
			light_r_q <= in_ch.light_right;
			e_rear_q  <= e_rear_in;
			e_align_q <= e_align_in;
			rdiff_q   <= primed_q ? DIFF_W'(e_rear_in) - DIFF_W'(rear_prev_q) : '0;
			adiff_q   <= primed_q ? DIFF_W'(e_align_in) - DIFF_W'(align_prev_q) : '0;
		end
		if (state_q == ST_RDIV && div_rsp.done) d_rear_q <= div_rsp.quotient;
		if (state_q == ST_ADIV && div_rsp.done) d_align_q <= div_rsp.quotient;
		// distance term has unit gains: base + error + integral + derivative
		if (state_q == ST_KP) begin
			rt_q <= AW'(rear_int_q) + AW'(e_rear_q) + AW'(d_rear_q) + AW'(BASE_POWER);
		end
		if (state_q == ST_KI) al_q <= prod_x;
		if (state_q == ST_KD || state_q == ST_SUM) al_q <= al_q + prod_x;
		if (state_q == ST_MIX) begin
			right_q <= rt_q + al_q;
			left_q  <= rt_q - al_q;
		end
	end

	// -------------------------------------------------------------------------
	// Clamp, thruster rule and output register
	// -------------------------------------------------------------------------
	assign pr_clamp = clamp_power(right_q, power_max_q, power_min_q);
	assign pl_clamp = clamp_power(left_q, power_max_q, power_min_q);

	// a thruster enabled by the lane fires when its light sensor is off the line
	always_comb begin
		thr_r_d = 1'b0;
		thr_l_d = 1'b0;
		case (lane_q)
			LANE_ONE: thr_r_d = (light_r_q >= line_thresh_q);
			LANE_TWO: begin
				thr_r_d = (light_r_q >= line_thresh_q);
				thr_l_d = (light_l_q >= line_thresh_q);
			end
			LANE_THREE: thr_l_d = (light_l_q >= line_thresh_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			power_right_q <= pr_clamp;
			power_left_q  <= pl_clamp;
			thr_r_q       <= thr_r_d;
			thr_l_q       <= thr_l_d;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.power_right       = power_right_q;
	assign out_ch.power_left        = power_left_q;
	assign out_ch.thruster_right_on = thr_r_q;
	assign out_ch.thruster_left_on  = thr_l_q;

	// -------------------------------------------------------------------------
	// Checks
	// -------------------------------------------------------------------------
	`DPDD_ASSERT_NEXT(a_busy_after_accept, arst_n, in_fire, !in_ch.ready, "ready after accept")
	`DPDD_ASSERT_NEXT(a_result_shown, arst_n, out_load, out_ch.valid, "result beat not shown")
	`DPDD_ASSERT_HOLDS(a_div_done_in_div_state, arst_n, div_rsp.done, (state_q == ST_RDIV || state_q == ST_ADIV), "divider done outside a divide step")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual PID differential drive - testbench
// Sends sensor samples through the valid/ready input channel and checks every
// drive command against an in-bench model of both PID loops and the mixer, or
// against a command typed into the directed table. A directed table covers
// reset, extreme fields, every lane and the clamp corner cases. Randomized
// phases then change the registers and run closed-loop tracking, noise and
// integral wind-up, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
	import dpdd_pkg::*;

	localparam int INTEG_W    = INTEGRAL_WIDTH_DEF;
	localparam int DIST_MAX   = (1 << DIST_W) - 1;
	localparam int LIGHT_MAX  = (1 << LIGHT_W) - 1;
	localparam int DT_MAX     = (1 << DT_W) - 1;
	localparam int POWER_MAX  = (1 << POWER_W) - 1;
	localparam int IDLE_LIMIT = 3000;   // cycles without any beat before giving up
	localparam int SETTLE_CYC = 40;     // a bit more than one sample's compute time
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 100;
	localparam int WINDUP_PHASE = 4;
	localparam int UNWIND_PHASE = 5;
	localparam int WINDUP_ITEMS = 70;   // enough max-error beats to hit +full scale
	localparam int UNWIND_ITEMS = 140;  // swing all the way to -full scale
	localparam longint ACCUM_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
	localparam longint ACCUM_LO = -ACCUM_HI - 1;
	localparam logic [LANE_W-1:0] LANE_NONE = '0;

	typedef struct packed {
		logic [DIST_W-1:0]  rear_distance;
		logic [DIST_W-1:0]  side_front_distance;
		logic [DIST_W-1:0]  side_rear_distance;
		logic [LIGHT_W-1:0] light_left;
		logic [LIGHT_W-1:0] light_right;
		logic [DT_W-1:0]    elapsed_ms;
	} sample_t;

	typedef struct packed {
		logic [POWER_W-1:0] power_right;
		logic [POWER_W-1:0] power_left;
		logic               thruster_right_on;
		logic               thruster_left_on;
	} drive_t;

	// One row of the directed table: either a register write or a sample,
	// optionally with the drive command typed in.
	typedef struct packed {
		logic                  is_write;
		cfg_reg_t              reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  has_want;
		sample_t               smp;
		drive_t                want;
	} step_t;

	typedef enum {MODE_TRACK, MODE_NOISE, MODE_ZERO_DT, MODE_EXTREME,
		MODE_WINDUP, MODE_UNWIND} stim_mode_t;
	typedef enum {RX_FREE, RX_COIN, RX_HICCUP, RX_CHOKE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dpdd_in_if  in_ch ();
	dpdd_out_if out_ch ();

	dual_pid_differential_drive #(
		.INTEGRAL_WIDTH(INTEG_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Drive model: register shadow, loop state and pending commands
	// ------------------------------------------------------------------
	logic [LANE_W-1:0]  cfg_lane;
	logic [DIST_W-1:0]  cfg_rear_target;
	logic [POWER_W-1:0] cfg_power_max;
	logic [POWER_W-1:0] cfg_power_min;
	logic [LIGHT_W-1:0] cfg_line_thresh;
	logic [GAIN_W-1:0]  cfg_kp;
	logic [GAIN_W-1:0]  cfg_ki;
	logic [GAIN_W-1:0]  cfg_kd;

	longint rear_err_last;
	longint align_err_last;
	longint rear_accum;
	longint align_accum;
	bit     loops_primed;

	drive_t pending_drive[$];
	drive_t oldest_drive;

	int mismatch_cnt;
	int samples_sent;
	int directed_cnt;
	int commands_checked;
	int settings_cnt;
	int accum_sat_hits;
	int idle_cycles;
	int gap_style;
	int burst_left;

	function automatic longint saturate_accum(longint v);
		if (v > ACCUM_HI) begin
			accum_sat_hits++;
			return ACCUM_HI;
		end
		if (v < ACCUM_LO) begin
			accum_sat_hits++;
			return ACCUM_LO;
		end
		return v;
	endfunction

	// Clamp to max first, then min: min wins when the two cross.
	function automatic logic [POWER_W-1:0] clamp_power(longint v);
		if (v > longint'(cfg_power_max))
			v = longint'(cfg_power_max);
		if (v < longint'(cfg_power_min))
			v = longint'(cfg_power_min);
		return v[POWER_W-1:0];
	endfunction

	// Advance both loops by one sample and return the resulting command.
	function automatic drive_t predict_drive(sample_t s);
		longint dt, e_rear, e_align, d_rear, d_align, rear_term, align_term;
		logic   off_line_r, off_line_l;
		drive_t r;
		r       = '0;
		dt      = longint'(s.elapsed_ms);
		e_rear  = longint'(cfg_rear_target) - longint'(s.rear_distance);
		e_align = longint'(s.side_front_distance) - longint'(s.side_rear_distance);
		// First sample after reset: no history, so the derivative is zero.
		if (!loops_primed) begin
			rear_err_last  = e_rear;
			align_err_last = e_align;
			loops_primed   = 1'b1;
		end
		rear_accum  = saturate_accum(rear_accum + e_rear * dt);
		align_accum = saturate_accum(align_accum + e_align * dt);
		d_rear  = 0;
		d_align = 0;
		if (dt != 0) begin
			d_rear  = (e_rear - rear_err_last) / dt;
			d_align = (e_align - align_err_last) / dt;
		end
		rear_err_last  = e_rear;
		align_err_last = e_align;
		rear_term  = e_rear + rear_accum + d_rear;
		align_term = longint'($signed(cfg_kp)) * e_align
			+ longint'($signed(cfg_ki)) * align_accum
			+ longint'($signed(cfg_kd)) * d_align;
		r.power_right = clamp_power(longint'(BASE_POWER) + rear_term + align_term);
		r.power_left  = clamp_power(longint'(BASE_POWER) + rear_term - align_term);
		off_line_r = (s.light_right >= cfg_line_thresh);
		off_line_l = (s.light_left >= cfg_line_thresh);
		case (cfg_lane)
			LANE_ONE: begin
				r.thruster_right_on = off_line_r;
			end
			LANE_TWO: begin
				r.thruster_right_on = off_line_r;
				r.thruster_left_on  = off_line_l;
			end
			LANE_THREE: begin
				r.thruster_left_on = off_line_l;
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic step_t known_step(int rd, int sf, int sr, int ll, int lr, int dt,
		int pr, int pl, int tr, int tl);
		step_t t;
		t = '0;
		t.smp.rear_distance       = DIST_W'(rd);
		t.smp.side_front_distance = DIST_W'(sf);
		t.smp.side_rear_distance  = DIST_W'(sr);
		t.smp.light_left          = LIGHT_W'(ll);
		t.smp.light_right         = LIGHT_W'(lr);
		t.smp.elapsed_ms          = DT_W'(dt);
		t.has_want                = 1'b1;
		t.want.power_right        = POWER_W'(pr);
		t.want.power_left         = POWER_W'(pl);
		t.want.thruster_right_on  = tr[0];
		t.want.thruster_left_on   = tl[0];
		return t;
	endfunction

	function automatic step_t item_step(int rd, int sf, int sr, int ll, int lr, int dt);
		step_t t;
		t = known_step(rd, sf, sr, ll, lr, dt, 0, 0, 0, 0);
		t.has_want = 1'b0;
		return t;
	endfunction

	function automatic step_t reg_step(cfg_reg_t r, int v);
		step_t t;
		t = '0;
		t.is_write = 1'b1;
		t.reg_sel  = r;
		t.reg_val  = CFG_DATA_W'(v);
		return t;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return GAIN_W'(-128);
			1: return GAIN_W'(127);
			2: return '0;
			3: return GAIN_W'(int'($urandom_range(0, 6)) - 3);
			default: return GAIN_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Build one random sample. Tracking mode reads the model's accumulators
	// and steers the error against them, so the loops stay near balance and
	// the power lands inside the clamps often enough to matter.
	function automatic sample_t make_sample(stim_mode_t mode);
		sample_t s;
		longint  pull, a2, er, ea;
		int      dt, lo;
		s.light_left  = LIGHT_W'($urandom_range(0, LIGHT_MAX));
		s.light_right = LIGHT_W'($urandom_range(0, LIGHT_MAX));
		s.rear_distance       = DIST_W'($urandom_range(0, DIST_MAX));
		s.side_front_distance = DIST_W'($urandom_range(0, DIST_MAX));
		s.side_rear_distance  = DIST_W'($urandom_range(0, DIST_MAX));
		s.elapsed_ms          = DT_W'($urandom_range(0, DT_MAX));
		case (mode)
			MODE_NOISE: ;
			MODE_ZERO_DT: s.elapsed_ms = '0;
			MODE_EXTREME: begin
				s.rear_distance       = $urandom_range(0, 1) ? DIST_W'(DIST_MAX) : '0;
				s.side_front_distance = $urandom_range(0, 1) ? DIST_W'(DIST_MAX) : '0;
				s.side_rear_distance  = $urandom_range(0, 1) ? DIST_W'(DIST_MAX) : '0;
				s.light_left  = $urandom_range(0, 1) ? LIGHT_W'(LIGHT_MAX) : '0;
				s.light_right = $urandom_range(0, 1) ? LIGHT_W'(LIGHT_MAX) : '0;
				case ($urandom_range(0, 2))
					0: s.elapsed_ms = '0;
					1: s.elapsed_ms = DT_W'(1);
					default: s.elapsed_ms = DT_W'(DT_MAX);
				endcase
			end
			MODE_WINDUP: begin
				s.rear_distance       = '0;
				s.side_front_distance = DIST_W'(DIST_MAX);
				s.side_rear_distance  = '0;
				s.elapsed_ms          = DT_W'($urandom_range(60000, DT_MAX));
			end
			MODE_UNWIND: begin
				s.rear_distance       = DIST_W'(DIST_MAX);
				s.side_front_distance = '0;
				s.side_rear_distance  = DIST_W'(DIST_MAX);
				s.elapsed_ms          = DT_W'($urandom_range(60000, DT_MAX));
			end
			default: begin
				dt   = $urandom_range(1, 40);
				pull = (rear_accum < 0) ? -rear_accum : rear_accum;
				a2   = (align_accum < 0) ? -align_accum : align_accum;
				if (a2 > pull)
					pull = a2;
				// Far from balance: stretch the interval so one beat pulls back hard.
				if (pull / dt > 400)
					dt = (pull / 400 >= DT_MAX) ? DT_MAX : int'(pull / 400 + 1);
				er = clip(-(rear_accum / dt) + int'($urandom_range(0, 16)) - 8,
					longint'(cfg_rear_target) - DIST_MAX, longint'(cfg_rear_target));
				ea = clip(-(align_accum / dt) + int'($urandom_range(0, 16)) - 8,
					-DIST_MAX, DIST_MAX);
				s.rear_distance = DIST_W'(longint'(cfg_rear_target) - er);
				if (ea >= 0) begin
					lo = $urandom_range(0, DIST_MAX - int'(ea));
					s.side_rear_distance  = DIST_W'(lo);
					s.side_front_distance = DIST_W'(lo + int'(ea));
				end else begin
					lo = $urandom_range(0, DIST_MAX + int'(ea));
					s.side_front_distance = DIST_W'(lo);
					s.side_rear_distance  = DIST_W'(lo - int'(ea));
				end
				s.elapsed_ms = DT_W'(dt);
			end
		endcase
		return s;
	endfunction

	// Write one register and mirror it in the model; the block is idle here.
	task automatic write_reg(cfg_reg_t r, int v);
		logic [CFG_DATA_W-1:0] d;
		case (r)
			REG_LANE: begin
				d = CFG_DATA_W'(v[LANE_W-1:0]);
				cfg_lane = v[LANE_W-1:0];
			end
			REG_REAR_TARGET: begin
				d = CFG_DATA_W'(v[DIST_W-1:0]);
				cfg_rear_target = v[DIST_W-1:0];
			end
			REG_POWER_MAX: begin
				d = CFG_DATA_W'(v[POWER_W-1:0]);
				cfg_power_max = v[POWER_W-1:0];
			end
			REG_POWER_MIN: begin
				d = CFG_DATA_W'(v[POWER_W-1:0]);
				cfg_power_min = v[POWER_W-1:0];
			end
			REG_LINE_THRESH: begin
				d = CFG_DATA_W'(v[LIGHT_W-1:0]);
				cfg_line_thresh = v[LIGHT_W-1:0];
			end
			REG_ALIGN_KP: begin
				d = CFG_DATA_W'(v[GAIN_W-1:0]);
				cfg_kp = v[GAIN_W-1:0];
			end
			REG_ALIGN_KI: begin
				d = CFG_DATA_W'(v[GAIN_W-1:0]);
				cfg_ki = v[GAIN_W-1:0];
			end
			default: begin
				d = CFG_DATA_W'(v[GAIN_W-1:0]);
				cfg_kd = v[GAIN_W-1:0];
			end
		endcase
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = r;
		cfg_data  = d;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Present one sample, hold it until the block takes the beat, then
	// queue the command it must produce.
	task automatic push_sample(sample_t s, logic has_want, drive_t want);
		drive_t model_cmd;
		@(negedge clk);
		in_ch.valid               = 1'b1;
		in_ch.rear_distance       = s.rear_distance;
		in_ch.side_front_distance = s.side_front_distance;
		in_ch.side_rear_distance  = s.side_rear_distance;
		in_ch.light_left          = s.light_left;
		in_ch.light_right         = s.light_right;
		in_ch.elapsed_ms          = s.elapsed_ms;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);
		model_cmd = predict_drive(s);
		pending_drive.push_back(has_want ? want : model_cmd);
		samples_sent++;
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
	endtask

	// Burst pacing: count down the burst, then idle for a gap whose length
	// depends on the phase's gap style.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 12);
			case (gap_style)
				0: ;
				1: hold_off($urandom_range(1, 6));
				default: hold_off($urandom_range(1, 45));
			endcase
		end
	endtask

	// Drop valid, wait for every command to come out, then let the
	// sequencer go quiet before touching the registers.
	task automatic settle();
		hold_off(1);
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatch_cnt++;
		if (mismatch_cnt <= 40)
			$display("%0t: mismatch on %s (command %0d): got %0d, want %0d",
				$realtime, what, commands_checked, got, want);
	endtask

	// ------------------------------------------------------------------
	// Receiver: stalls on its own pattern, switched among four random modes
	// ------------------------------------------------------------------
	initial begin
		rx_mode_t rx_mode;
		int       rx_len;
		int       choke_left;
		out_ch.ready = 1'b0;
		choke_left   = 0;
		forever begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_len  = $urandom_range(20, 300);
			repeat (rx_len) begin
				@(negedge clk);
				case (rx_mode)
					RX_FREE:   out_ch.ready = 1'b1;
					RX_COIN:   out_ch.ready = ($urandom_range(0, 1) != 0);
					RX_HICCUP: out_ch.ready = ($urandom_range(0, 7) != 0);
					default: begin
						// Long stalls with short windows open in between.
						if (choke_left > 0) begin
							choke_left--;
							out_ch.ready = 1'b0;
						end else begin
							out_ch.ready = 1'b1;
							if ($urandom_range(0, 3) == 0)
								choke_left = $urandom_range(30, 60);
						end
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Output checker: compare every beat against the oldest pending command
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_drive.size() == 0) begin
				report_mismatch("beat with nothing pending", 1, 0);
			end else begin
				oldest_drive = pending_drive.pop_front();
				if (out_ch.power_right !== oldest_drive.power_right)
					report_mismatch("power_right", out_ch.power_right,
						oldest_drive.power_right);
				if (out_ch.power_left !== oldest_drive.power_left)
					report_mismatch("power_left", out_ch.power_left,
						oldest_drive.power_left);
				if (out_ch.thruster_right_on !== oldest_drive.thruster_right_on)
					report_mismatch("thruster_right_on", out_ch.thruster_right_on,
						oldest_drive.thruster_right_on);
				if (out_ch.thruster_left_on !== oldest_drive.thruster_left_on)
					report_mismatch("thruster_left_on", out_ch.thruster_left_on,
						oldest_drive.thruster_left_on);
				commands_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any beat on either channel resets the idle count
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
			|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d commands still pending",
				$realtime, IDLE_LIMIT, pending_drive.size());
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		step_t      directed_tab[$];
		stim_mode_t mode;
		int         ph, k, n_items, pick;
		logic [POWER_W-1:0] pa, pb;

		// Known values on every input from time zero; hold reset.
		arst_n                    = 1'b0;
		cfg_we                    = 1'b0;
		cfg_index                 = REG_LANE;
		cfg_data                  = '0;
		in_ch.valid               = 1'b0;
		in_ch.rear_distance       = '0;
		in_ch.side_front_distance = '0;
		in_ch.side_rear_distance  = '0;
		in_ch.light_left          = '0;
		in_ch.light_right         = '0;
		in_ch.elapsed_ms          = '0;
		idle_cycles               = 0;
		mismatch_cnt              = 0;
		samples_sent              = 0;
		commands_checked          = 0;
		accum_sat_hits            = 0;
		settings_cnt              = 1;
		burst_left                = 0;
		gap_style                 = 1;

		// Model starts from the register reset values and cleared loops.
		cfg_lane        = RST_LANE;
		cfg_rear_target = RST_REAR_TARGET;
		cfg_power_max   = RST_POWER_MAX;
		cfg_power_min   = RST_POWER_MIN;
		cfg_line_thresh = RST_LINE_THRESH;
		cfg_kp          = RST_GAIN;
		cfg_ki          = RST_GAIN;
		cfg_kd          = RST_GAIN;
		rear_err_last   = 0;
		align_err_last  = 0;
		rear_accum      = 0;
		align_accum     = 0;
		loops_primed    = 1'b0;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. Typed commands only where the answer is obvious:
		// zero error from reset, or both clamps pinning the power.
		// Reset settings: first sample (derivative forced to zero), then zero
		// error with time running, then the distance extremes.
		directed_tab.push_back(known_step(30, 100, 100, 0, 1023, 0, 127, 127, 1, 0));
		directed_tab.push_back(known_step(30, 200, 200, 1023, 511, 1000, 127, 127, 0, 0));
		directed_tab.push_back(item_step(0, 511, 0, 1023, 1023, 65535));
		directed_tab.push_back(item_step(511, 0, 511, 0, 0, 1));
		directed_tab.push_back(item_step(511, 0, 511, 512, 512, 0));
		// Min above max: every command comes out at the min. Lane zero: no
		// thruster at all.
		directed_tab.push_back(reg_step(REG_POWER_MAX, 0));
		directed_tab.push_back(reg_step(REG_POWER_MIN, 255));
		directed_tab.push_back(reg_step(REG_LANE, LANE_NONE));
		directed_tab.push_back(known_step(0, 0, 0, 1023, 1023, 65535, 255, 255, 0, 0));
		directed_tab.push_back(known_step(511, 511, 511, 0, 1023, 0, 255, 255, 0, 0));
		// Lane three with threshold zero: left thruster always on.
		directed_tab.push_back(reg_step(REG_LANE, LANE_THREE));
		directed_tab.push_back(reg_step(REG_LINE_THRESH, 0));
		directed_tab.push_back(known_step(100, 5, 400, 0, 0, 7, 255, 255, 0, 1));
		// Lane two at the top threshold: each side follows its own sensor.
		directed_tab.push_back(reg_step(REG_LANE, LANE_TWO));
		directed_tab.push_back(reg_step(REG_LINE_THRESH, 1023));
		directed_tab.push_back(reg_step(REG_POWER_MIN, 0));
		directed_tab.push_back(known_step(200, 300, 100, 1023, 1022, 9, 0, 0, 0, 1));
		directed_tab.push_back(known_step(200, 300, 100, 1022, 1023, 65535, 0, 0, 1, 0));
		directed_tab.push_back(reg_step(REG_LANE, LANE_ONE));
		directed_tab.push_back(known_step(0, 511, 0, 1023, 1023, 0, 0, 0, 1, 0));
		// Gain extremes, open clamps: the model decides from here on.
		directed_tab.push_back(reg_step(REG_POWER_MAX, 255));
		directed_tab.push_back(reg_step(REG_REAR_TARGET, 511));
		directed_tab.push_back(reg_step(REG_ALIGN_KP, 127));
		directed_tab.push_back(reg_step(REG_ALIGN_KI, 0));
		directed_tab.push_back(reg_step(REG_ALIGN_KD, -128));
		directed_tab.push_back(reg_step(REG_LINE_THRESH, 512));
		directed_tab.push_back(item_step(0, 511, 0, 600, 100, 1));
		directed_tab.push_back(item_step(511, 0, 511, 100, 600, 3));
		directed_tab.push_back(item_step(255, 256, 255, 511, 512, 65535));
		directed_tab.push_back(reg_step(REG_ALIGN_KP, -128));
		directed_tab.push_back(reg_step(REG_ALIGN_KI, -1));
		directed_tab.push_back(reg_step(REG_ALIGN_KD, 127));
		directed_tab.push_back(reg_step(REG_REAR_TARGET, 0));
		directed_tab.push_back(item_step(511, 0, 511, 0, 1023, 2));
		directed_tab.push_back(item_step(0, 511, 0, 1023, 0, 0));
		directed_tab.push_back(item_step(0, 0, 511, 300, 700, 65535));

		// Walk the table; drain before the first write of each group.
		for (k = 0; k < directed_tab.size(); k++) begin
			if (directed_tab[k].is_write) begin
				if (k > 0 && !directed_tab[k - 1].is_write) begin
					settle();
					settings_cnt++;
				end
				write_reg(directed_tab[k].reg_sel, directed_tab[k].reg_val);
			end else begin
				push_sample(directed_tab[k].smp, directed_tab[k].has_want,
					directed_tab[k].want);
				pace();
			end
		end
		directed_cnt = samples_sent;

		// Random phases: new settings each time, then a mix of closed-loop
		// tracking, noise, zero-interval and extreme samples. One phase
		// winds both accumulators into positive saturation, the next one
		// drives them through zero into negative saturation.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			settings_cnt++;
			write_reg(REG_LANE, CFG_DATA_W'($urandom_range(0, 3)));
			case ($urandom_range(0, 4))
				0: write_reg(REG_REAR_TARGET, 0);
				1: write_reg(REG_REAR_TARGET, DIST_MAX);
				default: write_reg(REG_REAR_TARGET, CFG_DATA_W'($urandom_range(0, DIST_MAX)));
			endcase
			pa = POWER_W'($urandom_range(0, POWER_MAX));
			pb = POWER_W'($urandom_range(0, POWER_MAX));
			case ($urandom_range(0, 5))
				0: begin
					write_reg(REG_POWER_MAX, POWER_MAX);
					write_reg(REG_POWER_MIN, 0);
				end
				1: begin
					// crossed clamps
					write_reg(REG_POWER_MAX, CFG_DATA_W'($urandom_range(0, 127)));
					write_reg(REG_POWER_MIN, CFG_DATA_W'($urandom_range(128, POWER_MAX)));
				end
				2: begin
					write_reg(REG_POWER_MAX, pa);
					write_reg(REG_POWER_MIN, pa);
				end
				default: begin
					write_reg(REG_POWER_MAX, (pa > pb) ? pa : pb);
					write_reg(REG_POWER_MIN, (pa > pb) ? pb : pa);
				end
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(REG_LINE_THRESH, 0);
				1: write_reg(REG_LINE_THRESH, LIGHT_MAX);
				default: write_reg(REG_LINE_THRESH, CFG_DATA_W'($urandom_range(0, LIGHT_MAX)));
			endcase
			write_reg(REG_ALIGN_KP, pick_gain());
			write_reg(REG_ALIGN_KI, pick_gain());
			write_reg(REG_ALIGN_KD, pick_gain());
			// Wind-up needs the largest positive rear error, unwind the largest
			// negative one.
			if (ph == WINDUP_PHASE)
				write_reg(REG_REAR_TARGET, DIST_MAX);
			if (ph == UNWIND_PHASE)
				write_reg(REG_REAR_TARGET, 0);

			gap_style  = $urandom_range(0, 2);
			burst_left = 0;
			n_items    = (ph == UNWIND_PHASE) ? UNWIND_ITEMS + 20 : PHASE_ITEMS;
			for (k = 0; k < n_items; k++) begin
				if (ph == WINDUP_PHASE && k < WINDUP_ITEMS) begin
					mode = MODE_WINDUP;
				end else if (ph == UNWIND_PHASE && k < UNWIND_ITEMS) begin
					mode = MODE_UNWIND;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 62)
						mode = MODE_TRACK;
					else if (pick < 84)
						mode = MODE_NOISE;
					else if (pick < 90)
						mode = MODE_ZERO_DT;
					else
						mode = MODE_EXTREME;
				end
				push_sample(make_sample(mode), 1'b0, '0);
				pace();
			end
		end

		// Let the last commands drain, then wait out one more compute time.
		hold_off(1);
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC + 8) @(posedge clk);

		$display("covered %0d samples (%0d from the directed table) over %0d register settings",
			samples_sent, directed_cnt, settings_cnt);
		$display("checked %0d drive commands; accumulators saturated %0d times; %0d mismatches",
			commands_checked, accum_sat_hits, mismatch_cnt);
		if (mismatch_cnt == 0 && pending_drive.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
